// ----- hdl/integer_square_root_unit_macros.svh -----
// assertion macros for the integer square root unit
`ifndef INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ISR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/isr_pkg.sv -----
// package with the working type and one root recurrence step
`timescale 1ns / 1ps

package isr_pkg;

  localparam int unsigned ISR_RAD_W           = 32;
  localparam int unsigned ISR_ROOT_W          = 16;
  localparam int unsigned ISR_REM_W           = 17;
  localparam int unsigned ISR_STAGES          = 4;
  localparam int unsigned ISR_STEPS_PER_STAGE = 4;

  typedef struct packed {
    logic [ISR_RAD_W-1:0]  rad_rest;
    logic [ISR_ROOT_W-1:0] root;
    logic [ISR_REM_W-1:0]  rem;
    logic                  neg;
  } isr_work_t;

  // one digit of the shift-subtract root: bring down two radicand bits,
  // try 4*root+1 against the remainder
  function automatic isr_work_t isr_step(input isr_work_t w);
    logic [ISR_REM_W+1:0] acc;
    logic [ISR_REM_W+1:0] trial;
    isr_work_t            r;
    acc        = {w.rem, w.rad_rest[ISR_RAD_W-1 -: 2]};
    trial      = {1'b0, w.root, 2'b01};
    r          = w;
    r.rad_rest = {w.rad_rest[ISR_RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = ISR_REM_W'(acc - trial);
      r.root = {w.root[ISR_ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc[ISR_REM_W-1:0];
      r.root = {w.root[ISR_ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- hdl/isr_stage.sv -----
// one pipeline stage: four root digits and a stalling register
`timescale 1ns / 1ps

module isr_stage
  import isr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  isr_work_t up_work,
  output logic      dn_valid,
  input  logic      dn_ready,
  output isr_work_t dn_work
);

  logic      valid_r;
  isr_work_t work_r;
  isr_work_t work_nxt;

  // stage takes a new request when empty or when its content moves on
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    work_nxt = up_work;
    for (int i = 0; i < ISR_STEPS_PER_STAGE; i++) begin
      work_nxt = isr_step(work_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work_r <= work_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_work  = work_r;

endmodule

// ----- hdl/integer_square_root_unit.sv -----
// floor square root of a signed 32-bit radicand, four-stage pipeline
// an accepted request is registered in each stage in turn before it reaches out_tvalid
// throughput: one request per cycle while out_tready stays high; each of the four stages resolves four root bits
// a stalled output holds; upstream stages still fill any empty slots behind it
// reset clears the stage valid bits only; payload registers are not reset
`timescale 1ns / 1ps

module integer_square_root_unit
  import isr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] radicand
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] root
  output logic        out_tuser   // [0] negative_input
);

  logic      valid [ISR_STAGES+1];
  logic      ready [ISR_STAGES+1];
  isr_work_t work  [ISR_STAGES+1];

  assign valid[0]         = in_tvalid;
  assign in_tready        = ready[0];
  assign work[0].rad_rest = in_tdata;
  assign work[0].root     = '0;
  assign work[0].rem      = '0;
  assign work[0].neg      = in_tdata[ISR_RAD_W-1];

  for (genvar s = 0; s < ISR_STAGES; s++) begin : g_stage
    isr_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid[s]),
      .up_ready (ready[s]),
      .up_work  (work[s]),
      .dn_valid (valid[s+1]),
      .dn_ready (ready[s+1]),
      .dn_work  (work[s+1])
    );
  end

  assign ready[ISR_STAGES] = out_tready;
  assign out_tvalid        = valid[ISR_STAGES];
  // negative radicand reports a zero root
  assign out_tdata         = work[ISR_STAGES].neg ? '0 : work[ISR_STAGES].root;
  assign out_tuser         = work[ISR_STAGES].neg;

endmodule

// ----- hdl/isr_checker.sv -----
// port-level checker for the integer square root unit, bound to the top level
`timescale 1ns / 1ps
`include "integer_square_root_unit_macros.svh"

module isr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  `ISR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `ISR_ASSERT_NOW(a_neg_zero, out_tvalid && out_tuser, out_tdata == 16'd0, "negative radicand gave nonzero root")
  `ISR_ASSERT_NOW(a_root_max, out_tvalid && !out_tuser, out_tdata <= 16'd46340, "root above largest possible value")

endmodule

bind integer_square_root_unit isr_checker u_isr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- bench/integer_square_root_unit_tb.sv -----
// self-checking bench for the integer square root unit: directed and random requests
`timescale 1ns / 1ps

module integer_square_root_unit_tb;
  import isr_pkg::*;

  typedef struct packed {
    logic [ISR_ROOT_W-1:0] root;
    logic                  neg;
  } root_result_t;

  // floor square root, trial square formed at 64 bits so nothing wraps
  function automatic root_result_t predict_root(input logic [ISR_RAD_W-1:0] rad);
    root_result_t          res;
    logic [ISR_ROOT_W-1:0] partial;
    logic [ISR_ROOT_W-1:0] trial;
    logic [63:0]           sq;
    partial = '0;
    if (rad[ISR_RAD_W-1]) begin
      res.root = '0;
      res.neg  = 1'b1;
    end else begin
      for (int b = ISR_ROOT_W - 1; b >= 0; b--) begin
        trial = partial | (ISR_ROOT_W'(1) << b);
        sq    = 64'(trial) * 64'(trial);
        if (sq <= 64'(rad)) partial = trial;
      end
      res.root = partial;
      res.neg  = 1'b0;
    end
    return res;
  endfunction

  class root_scoreboard;
    root_result_t expected_roots[$];
    int           mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_radicand(input logic [ISR_RAD_W-1:0] rad);
      expected_roots.push_back(predict_root(rad));
    endfunction

    function void check_result(input logic [ISR_ROOT_W-1:0] root, input logic neg);
      root_result_t exp_res;
      if (expected_roots.size() == 0) begin
        $error("unexpected result: root %0d negative_input %0d", root, neg);
        mismatches++;
      end else begin
        exp_res = expected_roots.pop_front();
        if (root !== exp_res.root) begin
          $error("root: expected %0d, actual %0d", exp_res.root, root);
          mismatches++;
        end
        if (neg !== exp_res.neg) begin
          $error("negative_input: expected %0d, actual %0d", exp_res.neg, neg);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_request   = 1'b0;

  root_scoreboard sb = new();

  integer_square_root_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // receiver: random stalls, plus one long hold-off when asked
  int  hold_left   = 0;
  bit  hold_served = 1'b0;
  always @(posedge clk) begin
    if (hold_request && !hold_served) begin
      hold_left   = 400;
      hold_served = 1'b1;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic send_radicand(input logic [31:0] rad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rad;
    do @(posedge clk); while (!in_tready);
    sb.note_radicand(rad);
  endtask

  function automatic logic [31:0] random_radicand();
    logic [31:0] s;
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3:       v = $urandom_range(1000, 0);
      4, 5: begin
        // perfect squares and their neighbors
        s = $urandom_range(46340, 0);
        v = s * s + 32'($urandom_range(2, 0)) - 32'd1;
      end
      6:       v = 32'h7FFF_FFFF - 32'($urandom_range(100000, 0));
      7:       v = {1'b1, 31'($urandom)};
      8:       v = 32'h4000_0000 + 32'($urandom_range(2000, 0)) - 32'd1000;
      default: v = $urandom >> $urandom_range(31, 0);
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_radicand(random_radicand());
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
                 32'd65535, 32'd65536, 32'h3FFF_FFFF, 32'h4000_0000, 32'h4000_0001,
                 32'd2147395599, 32'd2147395600, 32'd2147395601, 32'h7FFF_FFFE,
                 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_radicand(directed[i]);

    // back to back, no idling
    send_random(500);

    send_idle_pct = 85;
    send_random(400);

    send_idle_pct = 0;
    recv_stall_pct <= 85;
    send_random(400);

    send_idle_pct = 34;
    recv_stall_pct <= 34;
    send_random(400);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_request <= 1'b1;
    send_random(250);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
